>>> src/slp_pkg.sv
`default_nettype none

package slp_pkg;

    localparam logic [7:0] SyncFirst  = 8'hAA;
    localparam logic [7:0] SyncSecond = 8'h55;
    localparam logic [7:0] KindSample = 8'h01;
    localparam logic [7:0] FrameLen   = 8'd8;

    localparam int SampleWidth = 32;

    typedef struct packed {
        logic [SampleWidth-1:0] red_sample;
        logic [SampleWidth-1:0] ir_sample;
    } sample_pair_t;

endpackage

`default_nettype wire

>>> src/sync_length_checksum_frame_parser.sv
`default_nettype none

// Serial frame parser: takes one received byte per beat, finds the sync pair
// 0xAA 0x55, checks a type byte, a length byte of 8, eight payload bytes and a
// mod-256 additive checksum over the twelve bytes before it. A good frame of
// type 0x01 yields one beat carrying the IR and red samples, each big-endian
// from the payload; every other frame is dropped. One byte is taken every
// clock cycle while the result buffer has space; a byte waits in the input
// register until the parser takes it, and the parser pushes a frame's result
// beat as it takes the checksum byte. A two-entry result buffer keeps input
// flowing while a result waits, and s_tready depends only on registers.

module sync_length_checksum_frame_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // rx_byte [7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata     // ir_sample [31:0], red_sample [63:32]
);
    import slp_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         consume;
    logic         has_space;
    logic         res_valid;
    sample_pair_t res;

    assign consume       = in_valid_reg && has_space;
    assign s_tready      = !in_valid_reg || consume;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !consume);

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    slp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (consume),
        .rx_byte    (in_byte_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    slp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .has_space (has_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

>>> src/slp_parser.sv
`default_nettype none

module slp_parser (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 byte_valid,
    input  wire logic [7:0]           rx_byte,
    output logic                      res_valid,
    output slp_pkg::sample_pair_t     res
);
    import slp_pkg::*;

    localparam logic [2:0] PH_SYNC1 = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_KIND  = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  kind_reg, kind_next;
    logic [63:0] shift_reg, shift_next;
    logic [2:0]  first_sync_phase;

    assign first_sync_phase = (rx_byte == SyncFirst) ? PH_SYNC2 : PH_SYNC1;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        kind_next  = kind_reg;
        shift_next = shift_reg;
        res_valid  = 1'b0;
        res.ir_sample  = shift_reg[63:32];
        res.red_sample = shift_reg[31:0];
        if (byte_valid) begin
            case (phase_reg)
                PH_SYNC2: begin
                    if (rx_byte == SyncSecond) begin
                        sum_next   = SyncFirst + SyncSecond;
                        phase_next = PH_KIND;
                    end else begin
                        phase_next = first_sync_phase;
                    end
                end
                PH_KIND: begin
                    kind_next  = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if (rx_byte == FrameLen) begin
                        sum_next   = sum_reg + rx_byte;
                        count_next = 4'd0;
                        shift_next = 64'd0;
                        phase_next = PH_DATA;
                    end else begin
                        phase_next = first_sync_phase;
                    end
                end
                PH_DATA: begin
                    sum_next   = sum_reg + rx_byte;
                    shift_next = {shift_reg[55:0], rx_byte};
                    count_next = count_reg + 4'd1;
                    if ({4'd0, count_next} >= FrameLen) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase_next = PH_SYNC1;
                    res_valid  = (sum_reg == rx_byte) && (kind_reg == KindSample);
                end
                default: begin
                    phase_next = first_sync_phase;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC1;
            count_reg <= 4'd0;
            sum_reg   <= 8'd0;
            kind_reg  <= 8'd0;
            shift_reg <= 64'd0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            kind_reg  <= kind_next;
            shift_reg <= shift_next;
        end
    end

endmodule

`default_nettype wire

>>> src/slp_out_buf.sv
`default_nettype none

module slp_out_buf (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire slp_pkg::sample_pair_t push_data,
    output logic                       has_space,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [63:0]                m_tdata    // ir_sample [31:0], red_sample [63:32]
);
    import slp_pkg::*;

    sample_pair_t slot_reg [2];
    logic [1:0]   count_reg, count_next;
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic         pop;

    assign has_space = (count_reg != 2'd2);
    assign m_tvalid  = (count_reg != 2'd0);
    assign pop       = m_tvalid && m_tready;
    assign m_tdata   = {slot_reg[rd_ptr_reg].red_sample, slot_reg[rd_ptr_reg].ir_sample};

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

`default_nettype wire
